/* src/sbe_pkg.sv */
// Package with the shared types and constants of the six-register bound executor.
`default_nettype none

package sbe_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_REGS    = 6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IP_REGISTER    = 2'd0,
        CFG_PROGRAM_LENGTH = 2'd1
    } t_cfg_index;

    typedef enum logic [3:0] {
        CMD_ADDR = 4'd0,
        CMD_ADDI = 4'd1,
        CMD_MULR = 4'd2,
        CMD_MULI = 4'd3,
        CMD_BANR = 4'd4,
        CMD_BANI = 4'd5,
        CMD_BORR = 4'd6,
        CMD_BORI = 4'd7,
        CMD_SETR = 4'd8,
        CMD_SETI = 4'd9,
        CMD_GTIR = 4'd10,
        CMD_GTRI = 4'd11,
        CMD_GTRR = 4'd12,
        CMD_EQIR = 4'd13,
        CMD_EQRI = 4'd14,
        CMD_EQRR = 4'd15
    } t_cmd;

    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_MUL = 3'd1,
        ALU_AND = 3'd2,
        ALU_OR  = 3'd3,
        ALU_SET = 3'd4,
        ALU_GT  = 3'd5,
        ALU_EQ  = 3'd6
    } t_alu_op;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [30:0] operand_a;
        logic [30:0] operand_b;
        logic [2:0]  dest_index;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] next_ip;
        logic               halted;
        logic               fault;
        logic signed [31:0] reg0_value;
        logic signed [31:0] reg1_value;
        logic signed [31:0] reg2_value;
        logic signed [31:0] reg3_value;
        logic signed [31:0] reg4_value;
        logic signed [31:0] reg5_value;
    } t_out_item;

    typedef struct packed {
        logic [2:0]            ip_register;
        logic [CFG_DATA_W-1:0] program_length;
    } t_cfg;

    typedef struct packed {
        t_alu_op     alu_op;
        logic        a_reg;
        logic        b_reg;
        logic [30:0] operand_a;
        logic [30:0] operand_b;
        logic [2:0]  dest_index;
        logic        idx_fault;
    } t_dec;

endpackage

`default_nettype wire

/* src/sbe_fifo.sv */
// Small register-based FIFO used for the instruction queue and the result queue.
`default_nettype none

module sbe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & ~o_empty;
    assign o_data    = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* src/sbe_front.sv */
// Front end: accepts instructions, decodes the opcode and checks register indexes.
`default_nettype none

module sbe_front #(
    parameter int NUM_REGS = 6
) (
    input  wire logic             i_push,
    input  wire sbe_pkg::t_in_item i_item,
    output logic                  o_full,
    input  wire logic             i_q_full,
    output logic                  o_q_push,
    output sbe_pkg::t_dec         o_dec
);

    import sbe_pkg::*;

    t_alu_op w_op;
    logic    w_a_reg;
    logic    w_b_reg;

    assign o_full   = i_q_full;
    assign o_q_push = i_push & ~i_q_full;

    always_comb begin
        unique case (t_cmd'(i_item.cmd))
            CMD_ADDR: begin w_op = ALU_ADD; w_a_reg = 1'b1; w_b_reg = 1'b1; end
            CMD_ADDI: begin w_op = ALU_ADD; w_a_reg = 1'b1; w_b_reg = 1'b0; end
            CMD_MULR: begin w_op = ALU_MUL; w_a_reg = 1'b1; w_b_reg = 1'b1; end
            CMD_MULI: begin w_op = ALU_MUL; w_a_reg = 1'b1; w_b_reg = 1'b0; end
            CMD_BANR: begin w_op = ALU_AND; w_a_reg = 1'b1; w_b_reg = 1'b1; end
            CMD_BANI: begin w_op = ALU_AND; w_a_reg = 1'b1; w_b_reg = 1'b0; end
            CMD_BORR: begin w_op = ALU_OR;  w_a_reg = 1'b1; w_b_reg = 1'b1; end
            CMD_BORI: begin w_op = ALU_OR;  w_a_reg = 1'b1; w_b_reg = 1'b0; end
            CMD_SETR: begin w_op = ALU_SET; w_a_reg = 1'b1; w_b_reg = 1'b0; end
            CMD_SETI: begin w_op = ALU_SET; w_a_reg = 1'b0; w_b_reg = 1'b0; end
            CMD_GTIR: begin w_op = ALU_GT;  w_a_reg = 1'b0; w_b_reg = 1'b1; end
            CMD_GTRI: begin w_op = ALU_GT;  w_a_reg = 1'b1; w_b_reg = 1'b0; end
            CMD_GTRR: begin w_op = ALU_GT;  w_a_reg = 1'b1; w_b_reg = 1'b1; end
            CMD_EQIR: begin w_op = ALU_EQ;  w_a_reg = 1'b0; w_b_reg = 1'b1; end
            CMD_EQRI: begin w_op = ALU_EQ;  w_a_reg = 1'b1; w_b_reg = 1'b0; end
            CMD_EQRR: begin w_op = ALU_EQ;  w_a_reg = 1'b1; w_b_reg = 1'b1; end
            default:  begin w_op = ALU_SET; w_a_reg = 1'b0; w_b_reg = 1'b0; end
        endcase
    end

    always_comb begin
        o_dec.alu_op     = w_op;
        o_dec.a_reg      = w_a_reg;
        o_dec.b_reg      = w_b_reg;
        o_dec.operand_a  = i_item.operand_a;
        o_dec.operand_b  = i_item.operand_b;
        o_dec.dest_index = i_item.dest_index;
        o_dec.idx_fault  = ({1'b0, i_item.dest_index} >= 4'(NUM_REGS))
                         || (w_a_reg && (i_item.operand_a >= 31'(NUM_REGS)))
                         || (w_b_reg && (i_item.operand_b >= 31'(NUM_REGS)));
    end

endmodule

`default_nettype wire

/* src/sbe_back.sv */
// Back end: register file and pointer; one instruction per cycle while output has room.
`default_nettype none

module sbe_back #(
    parameter int NUM_REGS   = 6,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sbe_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    input  wire sbe_pkg::t_dec i_dec,
    output logic               o_take,
    input  wire logic          i_out_full,
    output logic               o_out_push,
    output sbe_pkg::t_out_item o_result
);

    import sbe_pkg::*;

    logic [DATA_WIDTH-1:0] r_regs [NUM_REGS];
    logic [DATA_WIDTH-1:0] n_regs [NUM_REGS];
    logic [DATA_WIDTH-1:0] r_ip, n_ip;
    logic                  r_stopped, n_stopped;

    logic [DATA_WIDTH-1:0] w_bound [NUM_REGS];
    logic [DATA_WIDTH-1:0] w_after [NUM_REGS];
    logic [DATA_WIDTH-1:0] w_len;
    logic [DATA_WIDTH-1:0] w_va_reg, w_vb_reg, w_va, w_vb, w_res, w_nip;
    logic                  w_ip_ok, w_bad_ipreg, w_stop_next;
    logic                  w_halt, w_fault;
    logic signed [31:0]    w_regout [OUT_REGS];

    assign o_take     = i_valid & ~i_out_full;
    assign o_out_push = o_take;
    assign w_len      = DATA_WIDTH'(i_cfg.program_length);
    assign w_ip_ok    = ~r_ip[DATA_WIDTH-1] && (r_ip < w_len);
    assign w_bad_ipreg = ({1'b0, i_cfg.ip_register} >= 4'(NUM_REGS));

    always_comb begin
        w_va_reg = '0;
        w_vb_reg = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
            w_bound[i] = (i_cfg.ip_register == 3'(i)) ? r_ip : r_regs[i];
        end
        for (int i = 0; i < NUM_REGS; i++) begin
            if (i_dec.operand_a[2:0] == 3'(i)) begin
                w_va_reg = w_bound[i];
            end
            if (i_dec.operand_b[2:0] == 3'(i)) begin
                w_vb_reg = w_bound[i];
            end
        end
        w_va = i_dec.a_reg ? w_va_reg : DATA_WIDTH'(i_dec.operand_a);
        w_vb = i_dec.b_reg ? w_vb_reg : DATA_WIDTH'(i_dec.operand_b);
    end

    always_comb begin
        unique case (i_dec.alu_op)
            ALU_ADD: w_res = w_va + w_vb;
            ALU_MUL: w_res = w_va * w_vb;
            ALU_AND: w_res = w_va & w_vb;
            ALU_OR:  w_res = w_va | w_vb;
            ALU_SET: w_res = w_va;
            ALU_GT:  w_res = ($signed(w_va) > $signed(w_vb)) ? DATA_WIDTH'(1) : '0;
            ALU_EQ:  w_res = (w_va == w_vb) ? DATA_WIDTH'(1) : '0;
            default: w_res = '0;
        endcase
    end

    always_comb begin
        w_nip = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
            w_after[i] = (i_dec.dest_index == 3'(i)) ? w_res : w_bound[i];
        end
        for (int i = 0; i < NUM_REGS; i++) begin
            if (i_cfg.ip_register == 3'(i)) begin
                w_nip = w_after[i];
            end
        end
        w_nip       = w_nip + DATA_WIDTH'(1);
        w_stop_next = w_nip[DATA_WIDTH-1] || (w_nip >= w_len);
    end

    always_comb begin
        n_regs    = r_regs;
        n_ip      = r_ip;
        n_stopped = r_stopped;
        w_halt    = 1'b0;
        w_fault   = 1'b0;
        if (r_stopped || !w_ip_ok) begin
            n_stopped = 1'b1;
            w_halt    = 1'b1;
        end else if (i_dec.idx_fault || w_bad_ipreg) begin
            w_fault = 1'b1;
        end else begin
            n_regs    = w_after;
            n_ip      = w_nip;
            n_stopped = w_stop_next;
            w_halt    = w_stop_next;
        end
    end

    for (genvar j = 0; j < OUT_REGS; j++) begin : g_regout
        if (j < NUM_REGS) begin : g_live
            assign w_regout[j] = 32'(signed'(n_regs[j]));
        end else begin : g_zero
            assign w_regout[j] = '0;
        end
    end

    always_comb begin
        o_result.next_ip    = 32'(signed'(n_ip));
        o_result.halted     = w_halt;
        o_result.fault      = w_fault;
        o_result.reg0_value = w_regout[0];
        o_result.reg1_value = w_regout[1];
        o_result.reg2_value = w_regout[2];
        o_result.reg3_value = w_regout[3];
        o_result.reg4_value = w_regout[4];
        o_result.reg5_value = w_regout[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
            r_ip      <= '0;
            r_stopped <= 1'b0;
        end else if (o_take) begin
            r_regs    <= n_regs;
            r_ip      <= n_ip;
            r_stopped <= n_stopped;
        end
    end

endmodule

`default_nettype wire

/* src/six_register_ip_bound_executor_top.sv */
// Top level of the six-register executor with an instruction pointer bound to a register.
// Usage:
// Instructions enter through a queue-style port: a beat is taken on a rising edge where
// i_push is high and o_full is low. Results leave the same way: the oldest result sits on
// o_result while o_empty is low and is taken on an edge where i_pop is high.
// Every instruction beat produces exactly one result beat, in order.
// The configuration port (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) is always
// ready; index 0 selects the bound register, index 1 the program length. Write it only
// while no instruction is in flight.
// A taken instruction passes through the registered instruction queue, then the registered result queue.
// Throughput: one instruction per cycle while the result queue has room, set by the execute stage that reads
// the register file, runs the ALU (one multiplier) and writes the file back.
// A two-entry instruction queue sits between decode and execute and a two-entry result
// queue follows execute, so up to four beats may be outstanding. When the receiver stops
// popping, the result queue fills, execute holds, then the instruction queue fills and
// o_full rises.
// Synchronous reset clears the registers, the pointer, the halt flag, both queues and the
// configuration to zero; o_empty is high and o_full is low after reset.
`default_nettype none

module six_register_ip_bound_executor_top #(
    parameter int NUM_REGS   = 6,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    input  wire sbe_pkg::t_in_item                   i_item,
    output logic                                     o_full,
    input  wire logic                                i_pop,
    output sbe_pkg::t_out_item                       o_result,
    output logic                                     o_empty,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sbe_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [sbe_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import sbe_pkg::*;

    localparam int DEC_W = $bits(t_dec);
    localparam int RES_W = $bits(t_out_item);

    t_cfg             r_cfg;
    t_dec             w_dec_in, w_dec_q;
    logic [DEC_W-1:0] w_dec_q_bits;
    logic             w_iq_push, w_iq_full, w_iq_empty, w_iq_pop;
    t_out_item        w_res_in;
    logic [RES_W-1:0] w_res_q_bits;
    logic             w_oq_push, w_oq_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_IP_REGISTER:    r_cfg.ip_register    <= i_cfg_data[2:0];
                CFG_PROGRAM_LENGTH: r_cfg.program_length <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    sbe_front #(
        .NUM_REGS (NUM_REGS)
    ) u_front (
        .i_push   (i_push),
        .i_item   (i_item),
        .o_full   (o_full),
        .i_q_full (w_iq_full),
        .o_q_push (w_iq_push),
        .o_dec    (w_dec_in)
    );

    sbe_fifo #(
        .WIDTH (DEC_W),
        .DEPTH (2)
    ) u_inst_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_iq_push),
        .i_data  (w_dec_in),
        .o_full  (w_iq_full),
        .i_pop   (w_iq_pop),
        .o_data  (w_dec_q_bits),
        .o_empty (w_iq_empty)
    );

    assign w_dec_q = t_dec'(w_dec_q_bits);

    sbe_back #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (~w_iq_empty),
        .i_dec      (w_dec_q),
        .o_take     (w_iq_pop),
        .i_out_full (w_oq_full),
        .o_out_push (w_oq_push),
        .o_result   (w_res_in)
    );

    sbe_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_oq_push),
        .i_data  (w_res_in),
        .o_full  (w_oq_full),
        .i_pop   (i_pop),
        .o_data  (w_res_q_bits),
        .o_empty (o_empty)
    );

    assign o_result = t_out_item'(w_res_q_bits);

    a_halt_excludes_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> !(o_result.halted && o_result.fault))
        else $error("result carries both halted and fault");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_full) |-> $past(i_push))
        else $error("instruction queue filled without a push");

    a_exec_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_oq_push |-> (!w_iq_empty && !w_oq_full))
        else $error("execute fired without an instruction or result space");

endmodule

`default_nettype wire

/* verif/six_register_ip_bound_executor_top_test.sv */
// Self-checking testbench for the six-register executor with a bound instruction pointer.
`timescale 1ns / 1ps

import sbe_pkg::*;

class bound_ip_machine;
    logic [31:0] regs [OUT_REGS];
    logic [31:0] ip_ptr;
    bit          stopped;
    logic [2:0]  cfg_ipr;
    logic [15:0] cfg_len;
    t_out_item   want_q [$];
    int          errors;

    function new();
        foreach (regs[i]) regs[i] = '0;
        ip_ptr  = '0;
        stopped = 1'b0;
        cfg_ipr = '0;
        cfg_len = '0;
        errors  = 0;
    endfunction

    function void set_register(t_cfg_index idx, logic [15:0] data);
        case (idx)
            CFG_IP_REGISTER:    cfg_ipr = data[2:0];
            CFG_PROGRAM_LENGTH: cfg_len = data;
            default: ;
        endcase
    endfunction

    function bit in_program(logic [31:0] p);
        return !p[31] && (p < {16'd0, cfg_len});
    endfunction

    function t_out_item snapshot(logic [31:0] rr [OUT_REGS], logic [31:0] p, logic h, logic f);
        t_out_item o;
        o.next_ip    = p;
        o.halted     = h;
        o.fault      = f;
        o.reg0_value = rr[0];
        o.reg1_value = rr[1];
        o.reg2_value = rr[2];
        o.reg3_value = rr[3];
        o.reg4_value = rr[4];
        o.reg5_value = rr[5];
        return o;
    endfunction

    // Runs one instruction; with commit low the machine state is left untouched.
    function t_out_item execute(t_in_item it, bit commit);
        logic [31:0] r [OUT_REGS];
        logic [31:0] va;
        logic [31:0] vb;
        logic [31:0] res;
        logic [31:0] nxt;
        bit          a_reg;
        bit          b_reg;
        bit          ends;
        t_cmd        op;
        op = t_cmd'(it.cmd);
        if (stopped || !in_program(ip_ptr)) begin
            if (commit) stopped = 1'b1;
            return snapshot(regs, ip_ptr, 1'b1, 1'b0);
        end
        a_reg = !(op inside {CMD_SETI, CMD_GTIR, CMD_EQIR});
        b_reg = op inside {CMD_ADDR, CMD_MULR, CMD_BANR, CMD_BORR,
                           CMD_GTIR, CMD_GTRR, CMD_EQIR, CMD_EQRR};
        if (cfg_ipr >= OUT_REGS || it.dest_index >= OUT_REGS ||
            (a_reg && it.operand_a >= OUT_REGS) || (b_reg && it.operand_b >= OUT_REGS)) begin
            return snapshot(regs, ip_ptr, 1'b0, 1'b1);
        end
        r = regs;
        r[cfg_ipr] = ip_ptr;
        va = a_reg ? r[it.operand_a[2:0]] : {1'b0, it.operand_a};
        vb = b_reg ? r[it.operand_b[2:0]] : {1'b0, it.operand_b};
        case (op)
            CMD_ADDR, CMD_ADDI:           res = va + vb;
            CMD_MULR, CMD_MULI:           res = va * vb;
            CMD_BANR, CMD_BANI:           res = va & vb;
            CMD_BORR, CMD_BORI:           res = va | vb;
            CMD_SETR, CMD_SETI:           res = va;
            CMD_GTIR, CMD_GTRI, CMD_GTRR: res = {31'd0, $signed(va) > $signed(vb)};
            default:                      res = {31'd0, va == vb};
        endcase
        r[it.dest_index] = res;
        nxt  = r[cfg_ipr] + 32'd1;
        ends = !in_program(nxt);
        if (commit) begin
            regs    = r;
            ip_ptr  = nxt;
            stopped = ends;
        end
        return snapshot(r, nxt, ends, 1'b0);
    endfunction

    function void take_instr(t_in_item it);
        want_q.insert(want_q.size(), execute(it, 1'b1));
    endfunction

    function int pending();
        return want_q.size();
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        if (want_q.size() == 0) begin
            errors++;
            $error("result beat with no instruction waiting");
            return;
        end
        want = want_q.pop_front();
        cmp_field("next_ip", want.next_ip, got.next_ip);
        cmp_field("halted", 32'(want.halted), 32'(got.halted));
        cmp_field("fault", 32'(want.fault), 32'(got.fault));
        cmp_field("reg0_value", want.reg0_value, got.reg0_value);
        cmp_field("reg1_value", want.reg1_value, got.reg1_value);
        cmp_field("reg2_value", want.reg2_value, got.reg2_value);
        cmp_field("reg3_value", want.reg3_value, got.reg3_value);
        cmp_field("reg4_value", want.reg4_value, got.reg4_value);
        cmp_field("reg5_value", want.reg5_value, got.reg5_value);
    endfunction
endclass

module six_register_ip_bound_executor_top_test;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES     = 10;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_push      = 1'b0;
    t_in_item    i_item      = '0;
    logic        i_pop       = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = CFG_IP_REGISTER;
    logic [15:0] i_cfg_data  = '0;
    logic        o_full;
    logic        o_empty;
    logic        o_cfg_ready;
    t_out_item   o_result;

    bound_ip_machine machine = new();
    bit push_gaps_on = 1'b1;
    bit pop_gaps_on  = 1'b1;
    int idle_cycles  = 0;

    int phase_ipr   [PHASES] = '{0, 5, 3, 7, 1, 4, 6, 2, 0, 5};
    int phase_len   [PHASES] = '{65535, 2, 7, 500, 300, 3, 1000, 12, 65535, 40};
    int phase_items [PHASES] = '{250, 60, 180, 30, 250, 120, 30, 250, 300, 150};

    six_register_ip_bound_executor_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_pop       (i_pop),
        .o_result    (o_result),
        .o_empty     (o_empty),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item mk(t_cmd c, logic [30:0] a, logic [30:0] b, logic [2:0] d);
        t_in_item it;
        it.cmd        = c;
        it.operand_a  = a;
        it.operand_b  = b;
        it.dest_index = d;
        return it;
    endfunction

    function automatic logic [30:0] draw_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 91) return 31'($urandom_range(0, 5));
        if (r < 93) return 31'($urandom_range(6, 7));
        if (r < 96) return 31'h7FFF_FFFF;
        if (r < 97) return 31'd0;
        return 31'($urandom());
    endfunction

    function automatic t_in_item draw_instr();
        t_in_item it;
        int       sel;
        it.cmd       = 4'($urandom_range(0, 15));
        it.operand_a = draw_operand();
        it.operand_b = draw_operand();
        sel = $urandom_range(0, 99);
        if (sel < 4) it.dest_index = 3'($urandom_range(6, 7));
        else if (sel < 14 && machine.cfg_ipr < OUT_REGS) it.dest_index = machine.cfg_ipr;
        else it.dest_index = 3'($urandom_range(0, 5));
        return it;
    endfunction

    task automatic push_instr(input t_in_item it);
        int g;
        i_push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        machine.take_instr(it);
        g = push_gaps_on ? gap_len() : 0;
        if (g > 0) begin
            i_push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Random instruction that keeps the program running; a jump back is used when none does.
    task automatic issue_instr();
        t_in_item  it;
        t_out_item peek;
        int        tries;
        it    = draw_instr();
        peek  = machine.execute(it, 1'b0);
        tries = 0;
        while (peek.halted && tries < 8) begin
            it    = draw_instr();
            peek  = machine.execute(it, 1'b0);
            tries++;
        end
        if (peek.halted) begin
            it = mk(CMD_SETI, 31'($urandom_range(0, int'(machine.cfg_len) - 2)),
                    31'($urandom()), machine.cfg_ipr);
        end
        push_instr(it);
    endtask

    task automatic drain();
        i_push <= 1'b0;
        while (machine.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [2:0] ipr, input logic [15:0] len);
        logic [15:0] ipr_word;
        ipr_word = {($urandom_range(0, 1) != 0) ? 13'($urandom()) : 13'd0, ipr};
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IP_REGISTER;
        i_cfg_data  <= ipr_word;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        machine.set_register(CFG_IP_REGISTER, ipr_word);
        i_cfg_index <= CFG_PROGRAM_LENGTH;
        i_cfg_data  <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        machine.set_register(CFG_PROGRAM_LENGTH, len);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int stall_left;
        int cyc;
        stall_left = 0;
        cyc        = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty) machine.check_result(o_result);
            cyc++;
            if (cyc % 300 == 0) pop_gaps_on = ($urandom_range(0, 2) != 0);
            if (stall_left > 0) begin
                i_pop <= 1'b0;
                stall_left--;
            end else begin
                i_pop <= 1'b1;
                if (pop_gaps_on && $urandom_range(0, 3) == 0) stall_left = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          halt_path;
        logic [15:0] final_len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register 2 holds the pointer here, so reading it returns the current address.
        write_config(3'd2, 16'hFFFF);
        push_instr(mk(CMD_SETI, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 3'd0));
        push_instr(mk(CMD_ADDI, 31'd0, 31'd1, 3'd1));
        push_instr(mk(CMD_ADDR, 31'd1, 31'd1, 3'd3));
        push_instr(mk(CMD_MULI, 31'd0, 31'h7FFF_FFFF, 3'd4));
        push_instr(mk(CMD_MULR, 31'd1, 31'd0, 3'd5));
        push_instr(mk(CMD_BANR, 31'd0, 31'd4, 3'd3));
        push_instr(mk(CMD_BANI, 31'd1, 31'h7FFF_FFFF, 3'd3));
        push_instr(mk(CMD_BORR, 31'd1, 31'd0, 3'd3));
        push_instr(mk(CMD_BORI, 31'd5, 31'd0, 3'd4));
        push_instr(mk(CMD_SETR, 31'd3, 31'h7FFF_FFFF, 3'd5));
        push_instr(mk(CMD_GTIR, 31'd0, 31'd3, 3'd0));
        push_instr(mk(CMD_GTRI, 31'd1, 31'd0, 3'd4));
        push_instr(mk(CMD_GTRR, 31'd0, 31'd1, 3'd3));
        push_instr(mk(CMD_EQIR, 31'h7FFF_FFFF, 31'd5, 3'd4));
        push_instr(mk(CMD_EQRI, 31'd2, machine.ip_ptr[30:0], 3'd4));
        push_instr(mk(CMD_EQRR, 31'd3, 31'd3, 3'd1));
        push_instr(mk(CMD_ADDR, 31'd6, 31'd0, 3'd0));
        push_instr(mk(CMD_MULR, 31'd0, 31'h7FFF_FFFF, 3'd0));
        push_instr(mk(CMD_BORI, 31'd0, 31'd0, 3'd7));
        push_instr(mk(CMD_GTIR, 31'h7FFF_FFFF, 31'd0, 3'd5));
        push_instr(mk(CMD_SETI, 31'd0, 31'h7FFF_FFFF, 3'd2));
        push_instr(mk(CMD_ADDI, 31'd2, 31'd9, 3'd2));
        push_instr(mk(CMD_MULR, 31'd2, 31'd2, 3'd0));

        for (int ph = 0; ph < PHASES; ph++) begin
            write_config(3'(phase_ipr[ph]), 16'(phase_len[ph]));
            push_gaps_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < phase_items[ph]; k++) issue_instr();
            // Jump back to the start so that the next program length still holds the pointer.
            if (machine.cfg_ipr < OUT_REGS) begin
                push_instr(mk(CMD_SETI, 31'd0, 31'($urandom()), machine.cfg_ipr));
            end
        end

        push_gaps_on = 1'b1;
        halt_path = $urandom_range(0, 1);
        write_config(3'($urandom_range(0, 5)), 16'd0);
        if (halt_path != 0) begin
            final_len = 16'($urandom_range(2, 65535));
            write_config(3'($urandom_range(0, 5)), final_len);
            push_instr(mk(CMD_SETI,
                          ($urandom_range(0, 1) != 0) ? 31'h7FFF_FFFF : 31'(final_len - 16'd1),
                          31'($urandom()), machine.cfg_ipr));
        end
        repeat (40) push_instr(draw_instr());

        drain();
        repeat (8) @(posedge i_clk);
        if (machine.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
